// File: rtl/core/conditional_contingency_counter_assert.svh
// Assertion macros used by the checker of this block.
`ifndef CONDITIONAL_CONTINGENCY_COUNTER_ASSERT_SVH
`define CONDITIONAL_CONTINGENCY_COUNTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define CCC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CCC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ccc_pkg.sv
package ccc_pkg;

    // Table geometry
    localparam int MAX_VARS    = 4;
    localparam int VALUE_BITS  = 4;
    localparam int COUNT_WIDTH = 20;
    localparam int MAX_CONDS   = 4;

    localparam int VAR_FIELDS  = 4;
    localparam int COND_FIELDS = 4;
    localparam int FIELD_W     = 4;
    localparam int INDEX_W     = 16;
    localparam int VSEL_W      = $clog2(VAR_FIELDS);

    // Register widths
    localparam int NVARS_W   = 3;
    localparam int CARD_W    = 5;
    localparam int NCOND_W   = 3;
    localparam int TARGETS_W = 16;

    // Port widths
    localparam int KIND_W    = 2;
    localparam int S_TDATA_W = 2 * VAR_FIELDS * FIELD_W + INDEX_W;
    localparam int M_TDATA_W = INDEX_W + 2 * COUNT_WIDTH;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    // Effective limits
    localparam logic [NVARS_W-1:0] VARS_CAP =
        NVARS_W'((MAX_VARS < VAR_FIELDS) ? MAX_VARS : VAR_FIELDS);
    localparam logic [NCOND_W-1:0] CONDS_CAP =
        NCOND_W'((MAX_CONDS < COND_FIELDS) ? MAX_CONDS : COND_FIELDS);
    localparam logic [CARD_W-1:0] CARD_CAP = CARD_W'(1 << VALUE_BITS);
    localparam logic [FIELD_W-1:0] VALUE_MASK = FIELD_W'((1 << VALUE_BITS) - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_NUM_VARS     = 3'd0;
    localparam logic [2:0] REG_CARD_0       = 3'd1;
    localparam logic [2:0] REG_CARD_1       = 3'd2;
    localparam logic [2:0] REG_CARD_2       = 3'd3;
    localparam logic [2:0] REG_CARD_3       = 3'd4;
    localparam logic [2:0] REG_COND_COUNT   = 3'd5;
    localparam logic [2:0] REG_COND_TARGETS = 3'd6;

endpackage

// File: rtl/core/conditional_contingency_counter.sv
// Conditional contingency counter: a joint frequency table of up to four
// variables held in one 64K x 20 simple dual-port RAM.
// Input channel (s_): one beat per item; tuser carries the kind (sample,
// read cell, clear table). Output channel (m_): exactly one beat per item,
// in item order; tuser flags a counted sample.
// Configuration over the APB port: the user must see that it is written only
// while the block is idle; the block itself does not enforce this.
// Item steps from accept to result beat loaded:
//   sample     the index multiply-add takes one variable per cycle, then
//              the table word is read, incremented and written back
//   read       the cell is read from the table
//   condition miss or unused kind: straight to the result
//   value out of range at variable k (from 0): the multiply-add stops there
//   clear      the table is zeroed over all 65536 words, one word a cycle
// One item is in flight at a time; the next is taken while a result beat
// still waits in the output register.
// Reset: registers return to their defaults, then a clearing pass over all 65536
// words zeroes the table with s_tready low (APB stays live).
// Receiver stall: the finished result waits for the output register; the
// block stops accepting once it holds both a waiting beat and a new result.
module conditional_contingency_counter (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // value_0..value_3, cond_value_0..cond_value_3, read_index
    input  logic [ccc_pkg::S_TDATA_W-1:0] s_tdata,
    // kind
    input  logic [ccc_pkg::KIND_W-1:0]    s_tuser,
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // cell_index, cell count, samples_counted
    output logic [ccc_pkg::M_TDATA_W-1:0] m_tdata,
    // accepted
    output logic [0:0]                    m_tuser,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ccc_pkg::PADDR_W-1:0]   paddr,
    input  logic [ccc_pkg::PDATA_W-1:0]   pwdata,
    output logic [ccc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import ccc_pkg::*;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_INDEX  = 6'b000100,
        ST_READ   = 6'b001000,
        ST_UPDATE = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    localparam int TABLE_DEPTH = 1 << INDEX_W;

    state_t state_reg, state_next;

    // configuration registers
    logic [NVARS_W-1:0]   num_vars_reg;
    logic [CARD_W-1:0]    card_reg [VAR_FIELDS];
    logic [NCOND_W-1:0]   cond_count_reg;
    logic [TARGETS_W-1:0] cond_targets_reg;

    // effective configuration
    logic [NVARS_W-1:0] nv_eff;
    logic [CARD_W-1:0]  card_eff [VAR_FIELDS];
    logic [NCOND_W-1:0] nc_eff;

    // input beat fields
    logic [FIELD_W-1:0] s_val  [VAR_FIELDS];
    logic [FIELD_W-1:0] s_cond [COND_FIELDS];
    logic [INDEX_W-1:0] s_read_index;
    logic               cond_ok;
    logic               cfg_wr;

    // item in flight
    logic [FIELD_W-1:0] item_val_reg [VAR_FIELDS];
    logic               is_sample_reg;
    logic               clear_item_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic [VSEL_W-1:0]  var_cnt_reg;
    logic [INDEX_W-1:0] clr_addr_reg;

    // index multiply-add, one variable per cycle
    logic [FIELD_W-1:0]        step_val;
    logic [CARD_W-1:0]         step_card;
    logic [INDEX_W+CARD_W-1:0] step_prod;
    logic [INDEX_W-1:0]        step_acc;
    logic                      step_bad;
    logic                      step_last;

    // table RAM
    logic [COUNT_WIDTH-1:0] count_mem [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   mem_we;
    logic [INDEX_W-1:0]     mem_waddr;
    logic [COUNT_WIDTH-1:0] mem_wdata;
    logic [COUNT_WIDTH-1:0] cnt_inc;

    // result and output
    logic [COUNT_WIDTH-1:0] total_reg;
    logic                   res_accepted_reg;
    logic [INDEX_W-1:0]     res_index_reg;
    logic [COUNT_WIDTH-1:0] res_count_reg;
    logic                   m_tvalid_reg;
    logic                   out_accepted_reg;
    logic [INDEX_W-1:0]     out_index_reg;
    logic [COUNT_WIDTH-1:0] out_count_reg;
    logic [COUNT_WIDTH-1:0] out_total_reg;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_WIDTH'(1);
    endfunction

    // ---- configuration clamps ----
    always_comb begin
        nv_eff = num_vars_reg;
        if (nv_eff == '0) begin
            nv_eff = NVARS_W'(1);
        end
        if (nv_eff > VARS_CAP) begin
            nv_eff = VARS_CAP;
        end
        nc_eff = (cond_count_reg > CONDS_CAP) ? CONDS_CAP : cond_count_reg;
        for (int i = 0; i < VAR_FIELDS; i++) begin
            card_eff[i] = card_reg[i];
            if (card_eff[i] == '0) begin
                card_eff[i] = CARD_W'(1);
            end
            if (card_eff[i] > CARD_CAP) begin
                card_eff[i] = CARD_CAP;
            end
        end
    end

    // ---- input beat unpacking and condition check ----
    always_comb begin
        for (int i = 0; i < VAR_FIELDS; i++) begin
            s_val[i] = s_tdata[i*FIELD_W +: FIELD_W] & VALUE_MASK;
        end
        for (int k = 0; k < COND_FIELDS; k++) begin
            s_cond[k] = s_tdata[(VAR_FIELDS + k)*FIELD_W +: FIELD_W];
        end
        s_read_index = s_tdata[2*VAR_FIELDS*FIELD_W +: INDEX_W];
        cond_ok = 1'b1;
        for (int k = 0; k < COND_FIELDS; k++) begin
            if ((NCOND_W'(k) < nc_eff) &&
                (s_cond[k] != cond_targets_reg[k*FIELD_W +: FIELD_W])) begin
                cond_ok = 1'b0;
            end
        end
    end

    // ---- index step ----
    always_comb begin
        step_val  = item_val_reg[var_cnt_reg];
        step_card = card_eff[var_cnt_reg];
        step_prod = idx_reg * step_card;
        step_acc  = INDEX_W'(step_prod + (INDEX_W+CARD_W)'(step_val));
        step_bad  = ({1'b0, step_val} >= step_card);
        step_last = (NVARS_W'(var_cnt_reg) == (nv_eff - NVARS_W'(1)));
    end

    // ---- sequencer ----
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == '1) begin
                    state_next = clear_item_reg ? ST_RESULT : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (s_tuser)
                        KIND_SAMPLE: state_next = cond_ok ? ST_INDEX : ST_RESULT;
                        KIND_READ:   state_next = ST_READ;
                        KIND_CLEAR:  state_next = ST_CLEAR;
                        default:     state_next = ST_RESULT;
                    endcase
                end
            end
            ST_INDEX: begin
                if (step_bad) begin
                    state_next = ST_RESULT;
                end else if (step_last) begin
                    state_next = ST_READ;
                end
            end
            ST_READ:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_RESULT;
            ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_wr   = psel && penable && pwrite && pready;

    // ---- table RAM: one write port, one registered read port ----
    assign cnt_inc   = sat_inc(rd_data_reg);
    assign mem_we    = (state_reg == ST_CLEAR) || ((state_reg == ST_UPDATE) && is_sample_reg);
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : idx_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : cnt_inc;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            count_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= count_mem[idx_reg];
    end

    // ---- control and datapath ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            clr_addr_reg     <= '0;
            clear_item_reg   <= 1'b0;
            total_reg        <= '0;
            m_tvalid_reg     <= 1'b0;
            num_vars_reg     <= NVARS_W'(1);
            for (int i = 0; i < VAR_FIELDS; i++) begin
                card_reg[i] <= CARD_W'(2);
            end
            cond_count_reg   <= '0;
            cond_targets_reg <= '0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr) begin
                unique case (paddr[4:2])
                    REG_NUM_VARS:     num_vars_reg     <= pwdata[NVARS_W-1:0];
                    REG_CARD_0:       card_reg[0]      <= pwdata[CARD_W-1:0];
                    REG_CARD_1:       card_reg[1]      <= pwdata[CARD_W-1:0];
                    REG_CARD_2:       card_reg[2]      <= pwdata[CARD_W-1:0];
                    REG_CARD_3:       card_reg[3]      <= pwdata[CARD_W-1:0];
                    REG_COND_COUNT:   cond_count_reg   <= pwdata[NCOND_W-1:0];
                    REG_COND_TARGETS: cond_targets_reg <= pwdata[TARGETS_W-1:0];
                    default: ;
                endcase
            end

            // beat taken downstream; in ST_RESULT the load below decides
            if (m_tready && (state_reg != ST_RESULT)) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + INDEX_W'(1);
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        for (int i = 0; i < VAR_FIELDS; i++) begin
                            item_val_reg[i] <= s_val[i];
                        end
                        is_sample_reg    <= (s_tuser == KIND_SAMPLE);
                        clear_item_reg   <= (s_tuser == KIND_CLEAR);
                        idx_reg          <= (s_tuser == KIND_READ) ? s_read_index : '0;
                        var_cnt_reg      <= '0;
                        res_accepted_reg <= 1'b0;
                        res_index_reg    <= '0;
                        res_count_reg    <= '0;
                        if (s_tuser == KIND_CLEAR) begin
                            total_reg <= '0;
                        end
                    end
                end
                ST_INDEX: begin
                    if (!step_bad) begin
                        idx_reg     <= step_acc;
                        var_cnt_reg <= var_cnt_reg + VSEL_W'(1);
                    end
                end
                ST_READ: ;
                ST_UPDATE: begin
                    res_index_reg <= idx_reg;
                    if (is_sample_reg) begin
                        res_accepted_reg <= 1'b1;
                        res_count_reg    <= cnt_inc;
                        total_reg        <= sat_inc(total_reg);
                    end else begin
                        res_count_reg <= rd_data_reg;
                    end
                end
                ST_RESULT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg     <= 1'b1;
                        out_accepted_reg <= res_accepted_reg;
                        out_index_reg    <= res_index_reg;
                        out_count_reg    <= res_count_reg;
                        out_total_reg    <= total_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---- APB read-back ----
    always_comb begin
        unique case (paddr[4:2])
            REG_NUM_VARS:     prdata = PDATA_W'(num_vars_reg);
            REG_CARD_0:       prdata = PDATA_W'(card_reg[0]);
            REG_CARD_1:       prdata = PDATA_W'(card_reg[1]);
            REG_CARD_2:       prdata = PDATA_W'(card_reg[2]);
            REG_CARD_3:       prdata = PDATA_W'(card_reg[3]);
            REG_COND_COUNT:   prdata = PDATA_W'(cond_count_reg);
            REG_COND_TARGETS: prdata = PDATA_W'(cond_targets_reg);
            default:          prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_accepted_reg;
    assign m_tdata  = {out_total_reg, out_count_reg, out_index_reg};

endmodule

// File: rtl/core/ccc_checker.sv
`include "conditional_contingency_counter_assert.svh"

module ccc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ccc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [0:0]                    m_tuser
);
    import ccc_pkg::*;

    logic                   s_beat;
    logic                   m_stall;
    logic [COUNT_WIDTH-1:0] m_count;
    logic [COUNT_WIDTH-1:0] m_total;

    assign s_beat  = s_tvalid && s_tready;
    assign m_stall = m_tvalid && !m_tready;
    assign m_count = m_tdata[INDEX_W +: COUNT_WIDTH];
    assign m_total = m_tdata[INDEX_W+COUNT_WIDTH +: COUNT_WIDTH];

    // a stalled result beat holds
    `CCC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_stall, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled beat changed")

    // one item at a time: no accept in the cycle after an accept
    `CCC_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_beat, !s_tready, "accepted back-to-back items")

    // table sweep after reset keeps the input closed, and no stale result
    `CCC_ASSERT_SAME(a_reset_sweep, aclk, aresetn, !$past(aresetn), !s_tready && !m_tvalid, "busy after reset")

    // a counted sample shows a non-zero cell count and total
    `CCC_ASSERT_SAME(a_counted_nonzero, aclk, aresetn, m_tvalid && m_tuser[0], (m_count != '0) && (m_total != '0), "zero count")

endmodule

bind conditional_contingency_counter ccc_checker u_ccc_checker (.*);

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import ccc_pkg::*;

    // Kind code left unused by the block: no state change, zero fields, total echoed.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // Cycles with no beat on either channel before the run is abandoned. A clear
    // sweep and the clearing pass after reset each cover all 65536 words quietly.
    localparam int STALL_LIMIT = 200000;

    // Input beat payload, lowest bits first: value_0..3, cond_value_0..3, read_index.
    typedef struct packed {
        logic [INDEX_W-1:0]              read_index;
        logic [COND_FIELDS-1:0][FIELD_W-1:0] cond_value;
        logic [VAR_FIELDS-1:0][FIELD_W-1:0]  value;
    } tally_data_t;

    // Result beat payload, lowest bits first: cell_index, cell count, samples_counted.
    typedef struct packed {
        logic [COUNT_WIDTH-1:0] samples_counted;
        logic [COUNT_WIDTH-1:0] hit_count;
        logic [INDEX_W-1:0]     cell_index;
    } tally_result_t;

    typedef struct packed {
        logic          accepted;
        tally_result_t beat;
    } tally_expect_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [KIND_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [0:0]            m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [PDATA_W-1:0]    pwdata;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    // Shadow of the block: register file, table and running total.
    logic [NVARS_W-1:0]     cfg_num_vars = 3'd1;
    logic [CARD_W-1:0]      cfg_card [VAR_FIELDS] = '{default: 5'd2};
    logic [NCOND_W-1:0]     cfg_cond_count = 3'd0;
    logic [TARGETS_W-1:0]   cfg_targets = 16'd0;
    bit   [COUNT_WIDTH-1:0] cell_tally [1 << INDEX_W];
    bit   [COUNT_WIDTH-1:0] sample_total;

    tally_expect_t      expected_tallies[$];
    logic [INDEX_W-1:0] recent_cells[$];     // recently counted cells, aimed at by reads

    int error_count    = 0;
    int idle_cycles    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    conditional_contingency_counter i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------

    // Out-of-range register values are clamped by the block, not rejected.
    function automatic int unsigned used_vars();
        int unsigned n;
        n = cfg_num_vars;
        if (n == 0) n = 1;
        if (n > VARS_CAP) n = VARS_CAP;
        return n;
    endfunction

    function automatic int unsigned used_card(input int k);
        int unsigned c;
        c = cfg_card[k];
        if (c == 0) c = 1;
        if (c > CARD_CAP) c = CARD_CAP;
        return c;
    endfunction

    function automatic int unsigned used_conds();
        int unsigned n;
        n = cfg_cond_count;
        if (n > CONDS_CAP) n = CONDS_CAP;
        return n;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v);
        return (v >= COUNT_MAX) ? COUNT_MAX : v + 1'b1;
    endfunction

    // Works out the result beat of one item and applies its effect to the shadow.
    function automatic tally_expect_t predict_tally(input logic [KIND_W-1:0] kind,
                                                    input tally_data_t item);
        tally_expect_t      res;
        logic               hit;
        int unsigned        flat;
        int unsigned        radix;
        logic [INDEX_W-1:0] slot;
        res = '0;
        if (kind == KIND_SAMPLE) begin
            hit  = 1'b1;
            flat = 0;
            // every active condition must match its target nibble
            for (int k = 0; k < used_conds(); k++) begin
                if (item.cond_value[k] != cfg_targets[4*k +: 4]) hit = 1'b0;
            end
            // mixed radix, first variable most significant
            if (hit) begin
                for (int k = 0; k < used_vars(); k++) begin
                    radix = used_card(k);
                    if (item.value[k] >= radix) hit = 1'b0;
                    else flat = flat * radix + item.value[k];
                end
            end
            if (hit) begin
                slot             = flat[INDEX_W-1:0];
                cell_tally[slot] = bump(cell_tally[slot]);
                sample_total     = bump(sample_total);
                res.accepted        = 1'b1;
                res.beat.cell_index = slot;
                res.beat.hit_count  = cell_tally[slot];
            end
        end else if (kind == KIND_READ) begin
            // reads beyond the configured table still return the RAM word
            res.beat.cell_index = item.read_index;
            res.beat.hit_count  = cell_tally[item.read_index];
        end else if (kind == KIND_CLEAR) begin
            foreach (cell_tally[n]) cell_tally[n] = '0;
            sample_total = '0;
        end
        res.beat.samples_counted = sample_total;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Bus drivers
    // ------------------------------------------------------------------

    // Setup cycle, then access cycle; pready is tied high so the access
    // completes at the first rising edge with penable set.
    task automatic apb_write(input logic [2:0] reg_index, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_index) inside
            REG_NUM_VARS:     cfg_num_vars = value[NVARS_W-1:0];
            REG_CARD_0, REG_CARD_1, REG_CARD_2, REG_CARD_3: begin
                cfg_card[2'(reg_index - REG_CARD_0)] = value[CARD_W-1:0];
            end
            REG_COND_COUNT:   cfg_cond_count = value[NCOND_W-1:0];
            REG_COND_TARGETS: cfg_targets = value[TARGETS_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic set_layout(input int nvars, input int c0, input int c1, input int c2,
                              input int c3, input int nconds, input int targets);
        apb_write(REG_NUM_VARS, nvars);
        apb_write(REG_CARD_0, c0);
        apb_write(REG_CARD_1, c1);
        apb_write(REG_CARD_2, c2);
        apb_write(REG_CARD_3, c3);
        apb_write(REG_COND_COUNT, nconds);
        apb_write(REG_COND_TARGETS, targets);
    endtask

    // Entered and left just after a falling edge. tvalid stays high on return,
    // so back-to-back calls keep the channel busy; gaps and drain lower it.
    task automatic send_item(input logic [KIND_W-1:0] kind, input tally_data_t item);
        tally_expect_t want;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        s_tuser  <= kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        want = predict_tally(kind, item);
        expected_tallies.push_back(want);
        if (want.accepted) begin
            recent_cells.push_back(want.beat.cell_index);
            if (recent_cells.size() > 16) void'(recent_cells.pop_front());
        end
        @(negedge aclk);
    endtask

    // Wait for every outstanding beat, plus a margin so the block is truly idle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_tallies.size() != 0) @(posedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Result checking and watchdog
    // ------------------------------------------------------------------

    always @(negedge aclk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge aclk) begin
        tally_expect_t want;
        tally_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_tallies.size() == 0) begin
                $error("result beat with nothing outstanding");
                error_count++;
            end else begin
                want = expected_tallies.pop_front();
                if (m_tuser[0] !== want.accepted) begin
                    $error("accepted: expected %0d, got %0d", want.accepted, m_tuser[0]);
                    error_count++;
                end
                if (got.cell_index !== want.beat.cell_index) begin
                    $error("cell_index: expected %0d, got %0d",
                           want.beat.cell_index, got.cell_index);
                    error_count++;
                end
                if (got.hit_count !== want.beat.hit_count) begin
                    $error("cell count: expected %0d, got %0d",
                           want.beat.hit_count, got.hit_count);
                    error_count++;
                end
                if (got.samples_counted !== want.beat.samples_counted) begin
                    $error("samples_counted: expected %0d, got %0d",
                           want.beat.samples_counted, got.samples_counted);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset layout: one variable of cardinality two, no conditions.
    task automatic test_reset_layout();
        send_item(KIND_SAMPLE, {16'h0000, 16'h0000, 16'h0000});
        send_item(KIND_SAMPLE, {16'h0000, 16'h0000, 16'h0001});
        send_item(KIND_SAMPLE, {16'h0000, 16'h0000, 16'h0002});   // beyond cardinality
        send_item(KIND_READ,   {16'h0001, 16'h0000, 16'h0000});
        send_item(KIND_READ,   {16'hFFFF, 16'hFFFF, 16'hFFFF});   // outside the table
        send_item(KIND_UNUSED, {16'hFFFF, 16'hFFFF, 16'hFFFF});
    endtask

    // Four variables of sixteen values: index spans the whole RAM.
    task automatic test_full_index_range();
        drain();
        set_layout(4, 16, 16, 16, 16, 0, 0);
        send_item(KIND_SAMPLE, {16'h0000, 16'hFFFF, 16'hFFFF});
        send_item(KIND_SAMPLE, {16'hFFFF, 16'hFFFF, 16'h0000});
        send_item(KIND_READ,   {16'hFFFF, 16'h0000, 16'h0000});
    endtask

    // Each condition on its own must veto the sample; over-range count clamps to four.
    task automatic test_condition_gating();
        drain();
        set_layout(2, 3, 5, 2, 2, 4, 16'hC3A5);
        send_item(KIND_SAMPLE, {16'h0000, 16'hC3A5, 16'h0042});
        for (int k = 0; k < COND_FIELDS; k++) begin
            send_item(KIND_SAMPLE, {16'h0000, 16'hC3A5 ^ (16'h8 << (4 * k)), 16'h0042});
        end
        drain();
        apb_write(REG_COND_COUNT, 7);
        send_item(KIND_SAMPLE, {16'h0000, 16'hC3A5, 16'h0042});
        drain();
        apb_write(REG_COND_COUNT, 0);
        send_item(KIND_SAMPLE, {16'h0000, 16'h5A3C, 16'h0011});
    endtask

    // Zero and over-range register values clamp instead of misbehaving.
    task automatic test_clamped_settings();
        drain();
        set_layout(0, 0, 2, 2, 2, 0, 0);                         // one variable, one value
        send_item(KIND_SAMPLE, {16'h0000, 16'h0000, 16'h0000});
        send_item(KIND_SAMPLE, {16'h0000, 16'h0000, 16'h0001});
        drain();
        set_layout(7, 31, 17, 0, 16, 0, 16'hFFFF);               // radices 16, 16, 1, 16
        send_item(KIND_SAMPLE, {16'h0000, 16'h0000, 16'hF0FF});
        send_item(KIND_SAMPLE, {16'h0000, 16'h0000, 16'hF1FF});
    endtask

    task automatic test_table_clear();
        drain();
        send_item(KIND_CLEAR,  {16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_item(KIND_READ,   {16'hFFFF, 16'h0000, 16'h0000});
        send_item(KIND_SAMPLE, {16'h0000, 16'h0000, 16'h0000});
    endtask

    // Mostly small radices so cells fill up; sometimes full range or odd values.
    task automatic random_layout();
        int cards[VAR_FIELDS];
        foreach (cards[k]) begin
            case ($urandom_range(3))
                0:       cards[k] = $urandom_range(0, 31);
                1:       cards[k] = 16;
                default: cards[k] = $urandom_range(1, 4);
            endcase
        end
        set_layout($urandom_range(0, 7), cards[0], cards[1], cards[2], cards[3],
                   $urandom_range(0, 7), $urandom_range(0, 16'hFFFF));
    endtask

    // Mostly well-formed samples that pass the conditions, plus reads aimed at
    // live cells, noise samples and the unused kind.
    task automatic run_random_phase(input int idle_pct, input int stall_pct, input int n_items);
        tally_data_t        item;
        logic [KIND_W-1:0]  kind;
        int                 pick;
        drain();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        item.value      = 16'($urandom);
        item.cond_value = 16'($urandom);
        item.read_index = 16'($urandom);
        send_item(KIND_CLEAR, item);
        for (int s = 0; s < 2; s++) begin
            drain();
            random_layout();
            for (int n = 0; n < n_items / 2; n++) begin
                item.value      = 16'($urandom);
                item.cond_value = 16'($urandom);
                item.read_index = 16'($urandom);
                pick = $urandom_range(99);
                if (pick < 72) begin
                    kind = KIND_SAMPLE;
                    for (int k = 0; k < COND_FIELDS; k++) begin
                        if ($urandom_range(99) >= 12) item.cond_value[k] = cfg_targets[4*k +: 4];
                    end
                    for (int k = 0; k < VAR_FIELDS; k++) begin
                        if ($urandom_range(99) < 92) begin
                            item.value[k] = FIELD_W'($urandom_range(used_card(k) - 1));
                        end
                    end
                end else if (pick < 94) begin
                    kind = KIND_READ;
                    if (recent_cells.size() != 0 && $urandom_range(99) < 60) begin
                        item.read_index = recent_cells[$urandom_range(recent_cells.size() - 1)];
                    end
                end else if (pick < 99) begin
                    kind = KIND_SAMPLE;
                end else begin
                    kind = KIND_UNUSED;
                end
                send_item(kind, item);
            end
        end
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = KIND_SAMPLE;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_layout();
        test_full_index_range();
        test_condition_gating();
        test_clamped_settings();
        test_table_clear();
        run_random_phase(0, 0, 412);
        run_random_phase(58, 0, 412);
        run_random_phase(0, 58, 412);
        run_random_phase(35, 35, 412);

        drain();
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/ccc_pkg.sv
rtl/core/conditional_contingency_counter.sv
rtl/core/ccc_checker.sv
bench/tb_top.sv
